>>> hdl/command_line_assembler_top_macros.svh
// Assertion macros for the command line assembler RTL.
// Depends on nothing; included by cla_back, the module that carries assertions.
`ifndef COMMAND_LINE_ASSEMBLER_TOP_MACROS_SVH
`define COMMAND_LINE_ASSEMBLER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define CLA_ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Same-cycle implication checked outside reset.
`define CLA_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define CLA_ASSERT_ALWAYS(label, clk, rst_n, prop, msg)
`define CLA_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> hdl/cla_pkg.sv
// Shared types, codes and sizes of the command line assembler.
// Depends on nothing; used by every module of the block.
package cla_pkg;

    localparam int LINE_CHARS  = 32;
    localparam int MAX_RESULTS = 32;
    localparam int IDX_W       = $clog2(LINE_CHARS);
    localparam int LEN_W       = $clog2(LINE_CHARS + 1);

    localparam int OP_W        = 2;
    localparam int BYTE_W      = 8;
    localparam int CAP_W       = 8;
    localparam int KIND_W      = 2;
    localparam int CHAR_W      = 7;
    localparam int CHAR_IDX_W  = 5;
    localparam int LINE_LEN_W  = 6;
    localparam int LIM_W       = CAP_W + 1;

    localparam logic [OP_W-1:0] OP_BYTE  = 2'd0;
    localparam logic [OP_W-1:0] OP_TAKE  = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;

    localparam logic [KIND_W-1:0] KIND_ACK    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CHAR   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NO_CMD = 2'd2;

    localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_DEL   = 8'h7F;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [BYTE_W-1:0] rx_byte;
        logic [CAP_W-1:0]  capacity;
    } req_word_t;

    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic [CHAR_W-1:0]     char_value;
        logic [CHAR_IDX_W-1:0] char_index;
        logic [LINE_LEN_W-1:0] line_length;
        logic                  line_pending;
        logic                  last;
    } rsp_word_t;

    typedef enum logic [2:0] {
        CMD_IGNORE,
        CMD_PRINT,
        CMD_ERASE,
        CMD_EOL,
        CMD_TAKE,
        CMD_FLUSH
    } cmd_code_t;

    typedef struct packed {
        cmd_code_t         code;
        logic [CHAR_W-1:0] ch;
        logic [CAP_W-1:0]  capacity;
    } cmd_t;

endpackage

>>> hdl/cla_front.sv
// Front end: accepts request words and classifies them into commands.
// Depends on cla_pkg; feeds cla_queue.
module cla_front (
    input  logic                 req_valid,
    output logic                 req_stall,
    input  cla_pkg::req_word_t   req_word,
    output logic                 push_valid,
    input  logic                 queue_full,
    output cla_pkg::cmd_t        push_cmd
);

    cla_pkg::cmd_code_t code;

    always_comb
    begin
        code = cla_pkg::CMD_IGNORE;
        case (req_word.operation)
            cla_pkg::OP_BYTE:
            begin
                if (req_word.rx_byte == cla_pkg::CH_CR || req_word.rx_byte == cla_pkg::CH_LF)
                begin
                    code = cla_pkg::CMD_EOL;
                end
                else if (req_word.rx_byte == cla_pkg::CH_BS ||
                         req_word.rx_byte == cla_pkg::CH_DEL)
                begin
                    code = cla_pkg::CMD_ERASE;
                end
                else if (req_word.rx_byte >= cla_pkg::CH_SPACE &&
                         req_word.rx_byte < cla_pkg::CH_DEL)
                begin
                    code = cla_pkg::CMD_PRINT;
                end
            end
            cla_pkg::OP_TAKE:  code = cla_pkg::CMD_TAKE;
            cla_pkg::OP_FLUSH: code = cla_pkg::CMD_FLUSH;
            default:           code = cla_pkg::CMD_IGNORE;
        endcase
    end

    assign push_cmd.code     = code;
    assign push_cmd.ch       = req_word.rx_byte[cla_pkg::CHAR_W-1:0];
    assign push_cmd.capacity = req_word.capacity;
    assign push_valid        = req_valid;
    assign req_stall         = queue_full;

endmodule

>>> hdl/cla_queue.sv
// Two-entry command queue between the front end and the back end.
// Depends on cla_pkg.
module cla_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    input  cla_pkg::cmd_t   push_cmd,
    output logic            full,
    output logic            pop_valid,
    input  logic            pop,
    output cla_pkg::cmd_t   pop_cmd
);

    cla_pkg::cmd_t                entry_reg [cla_pkg::QUEUE_DEPTH];
    logic [cla_pkg::QPTR_W-1:0]   head_reg;
    logic [cla_pkg::QPTR_W-1:0]   head_next;
    logic [cla_pkg::QPTR_W-1:0]   tail_reg;
    logic [cla_pkg::QPTR_W-1:0]   tail_next;
    logic [cla_pkg::QCNT_W-1:0]   count_reg;
    logic [cla_pkg::QCNT_W-1:0]   count_next;
    logic                         do_push;
    logic                         do_pop;

    assign full      = (count_reg == cla_pkg::QCNT_W'(cla_pkg::QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_cmd   = entry_reg[head_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        head_next  = do_pop  ? head_reg + cla_pkg::QPTR_W'(1) : head_reg;
        tail_next  = do_push ? tail_reg + cla_pkg::QPTR_W'(1) : tail_reg;
        count_next = count_reg + cla_pkg::QCNT_W'(do_push) - cla_pkg::QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[tail_reg] <= push_cmd;
        end
    end

endmodule

>>> hdl/cla_back.sv
// Back end: owns the line store and line state, executes commands and
// drives the response register. Depends on cla_pkg and the macro header.
`include "command_line_assembler_top_macros.svh"
module cla_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  cla_pkg::cmd_t       cmd,
    output logic                cmd_pop,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output cla_pkg::rsp_word_t  rsp_word
);

    typedef enum logic {
        ST_IDLE,
        ST_TAKE
    } state_t;

    state_t                       state_reg;
    state_t                       state_next;
    logic [cla_pkg::LEN_W-1:0]    len_reg;
    logic [cla_pkg::LEN_W-1:0]    len_next;
    logic                         pend_reg;
    logic                         pend_next;
    logic [cla_pkg::IDX_W-1:0]    idx_reg;
    logic [cla_pkg::IDX_W-1:0]    idx_next;
    logic [cla_pkg::LEN_W-1:0]    tlen_reg;
    logic [cla_pkg::LEN_W-1:0]    tlen_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    cla_pkg::rsp_word_t           out_word_reg;
    cla_pkg::rsp_word_t           out_word_next;

    logic [cla_pkg::CHAR_W-1:0]   mem [cla_pkg::LINE_CHARS];
    logic [cla_pkg::CHAR_W-1:0]   rd_data_reg;
    logic [cla_pkg::IDX_W-1:0]    rd_addr;
    logic                         wr_en;

    logic                         can_load;
    logic [cla_pkg::CAP_W-1:0]    cap_m1;
    logic [cla_pkg::LIM_W-1:0]    lim;
    logic [cla_pkg::LEN_W-1:0]    take_len;
    logic [cla_pkg::LEN_W-1:0]    idx_plus;

    assign can_load = !out_valid_reg || !rsp_stall;
    assign idx_plus = cla_pkg::LEN_W'(idx_reg) + cla_pkg::LEN_W'(1);

    // Characters delivered by a take: stored length clamped to capacity - 1.
    always_comb
    begin
        cap_m1 = cmd.capacity - cla_pkg::CAP_W'(1);
        lim    = {1'b0, cap_m1};
        if (lim > cla_pkg::LIM_W'(cla_pkg::MAX_RESULTS))
        begin
            lim = cla_pkg::LIM_W'(cla_pkg::MAX_RESULTS);
        end
        if (lim > cla_pkg::LIM_W'(cla_pkg::LINE_CHARS))
        begin
            lim = cla_pkg::LIM_W'(cla_pkg::LINE_CHARS);
        end
        take_len = (cla_pkg::LIM_W'(len_reg) < lim) ? len_reg : cla_pkg::LEN_W'(lim);
    end

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        pend_next      = pend_reg;
        idx_next       = idx_reg;
        tlen_next      = tlen_reg;
        out_valid_next = rsp_stall ? out_valid_reg : 1'b0;
        out_word_next  = out_word_reg;
        cmd_pop        = 1'b0;
        wr_en          = 1'b0;
        rd_addr        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && can_load)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.code)
                        cla_pkg::CMD_PRINT:
                        begin
                            if (!pend_reg && len_reg < cla_pkg::LEN_W'(cla_pkg::LINE_CHARS))
                            begin
                                wr_en    = 1'b1;
                                len_next = len_reg + cla_pkg::LEN_W'(1);
                            end
                        end
                        cla_pkg::CMD_ERASE:
                        begin
                            if (!pend_reg && len_reg != '0)
                            begin
                                len_next = len_reg - cla_pkg::LEN_W'(1);
                            end
                        end
                        cla_pkg::CMD_EOL:
                        begin
                            if (!pend_reg && len_reg != '0)
                            begin
                                pend_next = 1'b1;
                            end
                        end
                        cla_pkg::CMD_FLUSH:
                        begin
                            len_next  = '0;
                            pend_next = 1'b0;
                        end
                        cla_pkg::CMD_TAKE:
                        begin
                            if (cmd.capacity != '0 && pend_reg)
                            begin
                                len_next  = '0;
                                pend_next = 1'b0;
                                if (take_len != '0)
                                begin
                                    state_next = ST_TAKE;
                                    idx_next   = '0;
                                    tlen_next  = take_len;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase

                    // Every command but a take that starts a walk answers at once.
                    if (state_next == ST_IDLE)
                    begin
                        out_valid_next            = 1'b1;
                        out_word_next.char_value  = '0;
                        out_word_next.char_index  = '0;
                        out_word_next.line_pending = pend_next;
                        out_word_next.last        = 1'b1;
                        if (cmd.code == cla_pkg::CMD_TAKE)
                        begin
                            out_word_next.kind        = cla_pkg::KIND_NO_CMD;
                            out_word_next.line_length = '0;
                        end
                        else
                        begin
                            out_word_next.kind        = cla_pkg::KIND_ACK;
                            out_word_next.line_length = cla_pkg::LINE_LEN_W'(len_next);
                        end
                    end
                end
            end
            ST_TAKE:
            begin
                rd_addr = idx_reg;
                if (can_load)
                begin
                    rd_addr                    = idx_reg + cla_pkg::IDX_W'(1);
                    idx_next                   = idx_reg + cla_pkg::IDX_W'(1);
                    out_valid_next             = 1'b1;
                    out_word_next.kind         = cla_pkg::KIND_CHAR;
                    out_word_next.char_value   = rd_data_reg;
                    out_word_next.char_index   = cla_pkg::CHAR_IDX_W'(idx_reg);
                    out_word_next.line_length  = cla_pkg::LINE_LEN_W'(tlen_reg);
                    out_word_next.line_pending = 1'b0;
                    out_word_next.last         = (idx_plus == tlen_reg);
                    if (idx_plus == tlen_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            pend_reg      <= 1'b0;
            idx_reg       <= '0;
            tlen_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_word_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            pend_reg      <= pend_next;
            idx_reg       <= idx_next;
            tlen_reg      <= tlen_next;
            out_valid_reg <= out_valid_next;
            out_word_reg  <= out_word_next;
        end
    end

    // Line store: one write port at the fill position, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[len_reg[cla_pkg::IDX_W-1:0]] <= cmd.ch;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_word  = out_word_reg;

    `CLA_ASSERT_ALWAYS(a_len_bound, clk, rst_n, len_reg <= cla_pkg::LEN_W'(cla_pkg::LINE_CHARS), "stored length exceeds line size")
    `CLA_ASSERT_IMPLY(a_pend_nonempty, clk, rst_n, pend_reg, len_reg != '0, "pending line is empty")
    `CLA_ASSERT_IMPLY(a_walk_in_range, clk, rst_n, state_reg == ST_TAKE, (cla_pkg::LEN_W'(idx_reg) < tlen_reg) && !pend_reg, "take walk out of range")
    `CLA_ASSERT_IMPLY(a_no_pop_in_walk, clk, rst_n, state_reg == ST_TAKE, !cmd_pop, "command popped during take walk")

endmodule

>>> hdl/command_line_assembler_top.sv
// Top level of the command line assembler.
// Depends on cla_pkg, cla_front, cla_queue and cla_back.
//
// The block builds a command line from received serial bytes and hands a
// finished line out one character per response word. A request word carries
// an operation (received byte, take pending command, flush line), the byte
// and, for a take, the caller's buffer capacity including its terminator.
// Printable bytes are appended while there is room, backspace or DEL erase
// one character, and CR or LF close a non-empty line and mark it pending;
// while a line is pending every received byte is ignored. Each request word
// is first classified by the front end and parked in a two-entry command
// queue, so the request side keeps moving while the back end is busy or the
// response side stalls, until the queue is full. The back end executes one
// command per cycle while it is not walking a take and the response side
// does not stall: a byte, flush or unknown operation gives one acknowledge
// word with the resulting length and pending flag, and an empty or refused
// take gives one no-command word. A take with characters first primes the
// line store's registered read port and then emits one character word per
// cycle while the response side does not stall, up to 32, the last one
// flagged, and takes no new command meanwhile. The line store needs no
// clearing pass after reset: only entries below the stored length are used.
module command_line_assembler_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  cla_pkg::req_word_t  req_word,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output cla_pkg::rsp_word_t  rsp_word
);

    // Classified command travelling from front end to queue.
    logic           push_valid;
    logic           queue_full;
    cla_pkg::cmd_t  push_cmd;

    // Queue head as seen by the back end.
    logic           cmd_valid;
    logic           cmd_pop;
    cla_pkg::cmd_t  cmd;

    cla_front u_front (
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_word   (req_word),
        .push_valid (push_valid),
        .queue_full (queue_full),
        .push_cmd   (push_cmd)
    );

    cla_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .full       (queue_full),
        .pop_valid  (cmd_valid),
        .pop        (cmd_pop),
        .pop_cmd    (cmd)
    );

    // The back end holds all line state, so command order is kept exactly.
    cla_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp_word   (rsp_word)
    );

endmodule
